>>> rtl/wltm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed level trend monitor package
// Shared widths, constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package wltm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WINDOW_DEF = 8;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned MAG_W      = DATA_W + SCALE_W;
  localparam int unsigned STEP_W     = $clog2(MAG_W);

  localparam logic [DATA_W-1:0]  INTERVAL_RESET = 32'd60000;
  localparam logic [SCALE_W-1:0] TREND_SCALE    = 16'd60000;
  localparam logic [DATA_W-1:0]  SAT_POS        = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]  SAT_NEG        = 32'h8000_0000;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic finish;
    logic out_load;
  } wltm_cmd_t;

  typedef struct packed {
    logic trend_due;
  } wltm_sts_t;

endpackage

>>> rtl/wltm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading channel
// Valid/ready channel that carries one timestamped level reading per transfer.
// ----------------------------------------------------------------------------
interface wltm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] level_value;

  modport source (output valid, output now_ms, output level_value, input ready);
  modport sink   (input valid, input now_ms, input level_value, output ready);
endinterface

>>> rtl/wltm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one trend and statistics result per transfer.
// ----------------------------------------------------------------------------
interface wltm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] trend_per_minute;
  logic        [31:0] highest_level;
  logic        [31:0] lowest_level;
  logic        [31:0] reading_count;
  logic               sample_stored;
  logic               window_full;

  modport source (
    output valid, output trend_per_minute, output highest_level, output lowest_level,
    output reading_count, output sample_stored, output window_full, input ready
  );
  modport sink (
    input valid, input trend_per_minute, input highest_level, input lowest_level,
    input reading_count, input sample_stored, input window_full, output ready
  );
endinterface

>>> rtl/wltm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed level trend monitor datapath
// Statistics registers, sample ring, slope multiplier, serial divider and the
// result register.
// ----------------------------------------------------------------------------
module wltm_datapath #(
  parameter int unsigned WINDOW = wltm_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wltm_pkg::wltm_cmd_t              cmd,
  output wltm_pkg::wltm_sts_t              sts,
  input  logic                             cfg_wr_en,
  input  logic [wltm_pkg::DATA_W-1:0]      cfg_wr_data,
  input  logic [wltm_pkg::DATA_W-1:0]      in_now_ms,
  input  logic [wltm_pkg::DATA_W-1:0]      in_level_value,
  output logic signed [wltm_pkg::DATA_W-1:0] out_trend_per_minute,
  output logic [wltm_pkg::DATA_W-1:0]      out_highest_level,
  output logic [wltm_pkg::DATA_W-1:0]      out_lowest_level,
  output logic [wltm_pkg::DATA_W-1:0]      out_reading_count,
  output logic                             out_sample_stored,
  output logic                             out_window_full
);

  localparam int unsigned DW     = wltm_pkg::DATA_W;
  localparam int unsigned MW     = wltm_pkg::MAG_W;
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(WINDOW);

  logic [DW-1:0]     ring_lv [WINDOW];
  logic [DW-1:0]     ring_tm [WINDOW];

  logic [DW-1:0]     interval_r;
  logic [DW-1:0]     peak_r;
  logic [DW-1:0]     floor_r;
  logic [DW-1:0]     count_r;
  logic [DW-1:0]     last_time_r;
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DW-1:0]     trend_r;
  logic              due_r;
  logic              stored_r;
  logic [DW-1:0]     cur_lv_r;
  logic [DW-1:0]     cur_tm_r;
  logic [DW-1:0]     old_lv_r;
  logic [DW-1:0]     old_tm_r;
  logic              neg_r;
  logic              zero_r;
  logic [DW-1:0]     div_r;
  logic [DW-1:0]     rem_r;
  logic [MW-1:0]     quo_r;

  logic              store_now;
  logic [FILL_W-1:0] fill_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic [DW-1:0]     peak_nxt;
  logic [DW-1:0]     floor_nxt;
  logic              lv_neg;
  logic [DW-1:0]     diff_mag;
  logic [MW-1:0]     prod;
  logic [DW-1:0]     elapsed;
  logic [DW:0]       rem_sh;
  logic              rem_ge;
  logic [DW:0]       rem_sub;
  logic [DW-1:0]     trend_nxt;

  always_comb begin
    store_now = (fill_r == '0) || ((in_now_ms - last_time_r) >= interval_r);
    fill_nxt  = (fill_r < FULL_CNT) ? fill_r + FILL_W'(1) : fill_r;
    slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
    peak_nxt  = ((peak_r == '0) || (in_level_value > peak_r)) ? in_level_value : peak_r;
    floor_nxt = ((floor_r == '0) || (in_level_value < floor_r)) ? in_level_value : floor_r;
  end

  always_comb begin
    lv_neg   = cur_lv_r < old_lv_r;
    diff_mag = lv_neg ? (old_lv_r - cur_lv_r) : (cur_lv_r - old_lv_r);
    prod     = MW'(diff_mag) * MW'(wltm_pkg::TREND_SCALE);
    elapsed  = cur_tm_r - old_tm_r;
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[MW-1]};
    rem_ge  = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_comb begin
    if (zero_r) begin
      trend_nxt = '0;
    end else if (!neg_r) begin
      trend_nxt = (quo_r > MW'(wltm_pkg::SAT_POS)) ? wltm_pkg::SAT_POS : quo_r[DW-1:0];
    end else begin
      trend_nxt = (quo_r > MW'(wltm_pkg::SAT_NEG)) ? wltm_pkg::SAT_NEG : (~quo_r[DW-1:0] + 1'b1);
    end
  end

  assign sts.trend_due = due_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= wltm_pkg::INTERVAL_RESET;
      peak_r      <= '0;
      floor_r     <= '0;
      count_r     <= '0;
      last_time_r <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      trend_r     <= '0;
      due_r       <= 1'b0;
      stored_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        count_r  <= count_r + 1'b1;
        peak_r   <= peak_nxt;
        floor_r  <= floor_nxt;
        stored_r <= store_now;
        due_r    <= store_now && (fill_nxt == FULL_CNT);
        if (store_now) begin
          last_time_r <= in_now_ms;
          fill_r      <= fill_nxt;
          slot_r      <= slot_nxt;
          if (fill_nxt != FULL_CNT) begin
            trend_r <= '0;
          end
        end
      end
      if (cmd.finish) begin
        trend_r <= trend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_lv_r <= in_level_value;
      cur_tm_r <= in_now_ms;
      old_lv_r <= ring_lv[slot_nxt];
      old_tm_r <= ring_tm[slot_nxt];
      if (store_now) begin
        ring_lv[slot_r] <= in_level_value;
        ring_tm[slot_r] <= in_now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r  <= lv_neg;
      zero_r <= elapsed == '0;
      div_r  <= elapsed;
      rem_r  <= '0;
      quo_r  <= prod;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[MW-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_trend_per_minute <= signed'(trend_r);
      out_highest_level    <= peak_r;
      out_lowest_level     <= floor_r;
      out_reading_count    <= count_r;
      out_sample_stored    <= stored_r;
      out_window_full      <= fill_r == FULL_CNT;
    end
  end

endmodule

>>> rtl/wltm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed level trend monitor controller
// Sequences acceptance, the slope multiply, the division steps and the result
// transfer, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module wltm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  wltm_pkg::wltm_sts_t sts,
  output wltm_pkg::wltm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [wltm_pkg::STEP_W-1:0] LAST_STEP = wltm_pkg::STEP_W'(wltm_pkg::MAG_W - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [wltm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        step_nxt = '0;
        if (sts.trend_due) begin
          cmd.mul   = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/windowed_level_trend_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed level trend monitor
// Counts timestamped level readings, tracks the highest and lowest level, keeps
// a ring of periodic samples and reports the saturated level change per minute.
// ----------------------------------------------------------------------------
// The block takes one reading at a time and returns one result for each. A
// reading that is not stored, or that is stored without filling the ring,
// goes from acceptance straight to the result load. A reading that is stored
// and leaves the ring full recomputes the trend: the accept state reads the
// oldest ring sample, the multiply state forms the 48-bit scaled difference,
// the restoring divider then retires one quotient bit per cycle, and the
// finish state saturates before the result register is loaded. That load is
// held while an earlier result is not yet taken. The next reading is taken as
// soon as the result is loaded, even while it still waits on the output channel.
module windowed_level_trend_monitor_top #(
  parameter int unsigned WINDOW = wltm_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  wltm_in_if.sink     in_ch,
  wltm_out_if.source  out_ch
);

  wltm_pkg::wltm_cmd_t cmd;
  wltm_pkg::wltm_sts_t sts;

  wltm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wltm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_now_ms            (in_ch.now_ms),
    .in_level_value       (in_ch.level_value),
    .out_trend_per_minute (out_ch.trend_per_minute),
    .out_highest_level    (out_ch.highest_level),
    .out_lowest_level     (out_ch.lowest_level),
    .out_reading_count    (out_ch.reading_count),
    .out_sample_stored    (out_ch.sample_stored),
    .out_window_full      (out_ch.window_full)
  );

endmodule

>>> rtl/wltm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed level trend monitor checker
// Port-level checks of the monitor's handshakes and result consistency.
// ----------------------------------------------------------------------------
module wltm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] trend_per_minute,
  input logic [31:0] highest_level,
  input logic [31:0] lowest_level,
  input logic [31:0] reading_count,
  input logic        window_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(trend_per_minute)
      && $stable(reading_count))
    else $error("Result changed or dropped while stalled.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Reading accepted while the previous one is still in work.");

  a_trend_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !window_full |-> trend_per_minute == 32'd0)
    else $error("Nonzero trend reported before the window is full.");

  a_low_not_above_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lowest_level <= highest_level)
    else $error("Lowest level exceeds highest level.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind windowed_level_trend_monitor_top wltm_checker u_wltm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .trend_per_minute (out_ch.trend_per_minute),
  .highest_level    (out_ch.highest_level),
  .lowest_level     (out_ch.lowest_level),
  .reading_count    (out_ch.reading_count),
  .window_full      (out_ch.window_full)
);
